FILE: rtl/pggc_pkg.sv
// ----------------------------------------------------------------------------
// pggc_pkg
// shared types and constants of the greedy graph coloring block
// ----------------------------------------------------------------------------
`default_nettype none

package pggc_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int NODE_W        = 6;
  localparam int COUNT_W       = 7;
  localparam int LIMIT_W       = 11;
  localparam int COLOR_W       = 6;
  localparam int PASS_W        = 12;

  localparam logic [1:0] CMD_EDGE  = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_NODE_COUNT  = 1'b0;
  localparam logic REG_COLOR_LIMIT = 1'b1;

  localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_E_RDA,
    ST_E_WRA,
    ST_E_WRB,
    ST_DEG_RD,
    ST_DEG_LD,
    ST_DEG_CNT,
    ST_DEG_WR,
    ST_RK_RDI,
    ST_RK_LDI,
    ST_RK_RDJ,
    ST_RK_CMP,
    ST_RK_WR,
    ST_CP_RDI,
    ST_CP_LDI,
    ST_CP_RDJ,
    ST_CP_CHK,
    ST_CP_SCAN,
    ST_CP_WR,
    ST_CP_END,
    ST_OUT_RD,
    ST_OUT_WR
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/pggc_ram.sv
// ----------------------------------------------------------------------------
// pggc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module pggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/parallel_greedy_graph_coloring.sv
// ----------------------------------------------------------------------------
// parallel_greedy_graph_coloring
// degree ordered synchronous greedy coloring of an interference graph
// ----------------------------------------------------------------------------
// An edge request steps through E_RDA, E_WRA and E_WRB; a clear request is
// taken in idle. A run request computes degrees, ranks the nodes, then runs
// coloring passes, each with a free color scan per node, and then reports;
// the degree count walks one neighbor per cycle, the ranking and the passes
// read and then compare one neighbor at a time through single read port
// rams. Results come on out_valid, one per OUT_RD/OUT_WR pair, and cannot be
// held off. busy stays high for the whole edge or run request, never for a
// clear, and for a run drops in the cycle that shows the last result.
`default_nettype none

module parallel_greedy_graph_coloring #(
  parameter int MAX_NODES = pggc_pkg::MAX_NODES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  node_a,
  input  wire logic [5:0]  node_b,
  output logic             out_valid,
  output logic [5:0]       node,
  output logic [5:0]       node_color,
  output logic [5:0]       rank,
  output logic [10:0]      passes,
  output logic             failed,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int NL = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int IW = $clog2(NL);
  localparam int CW = pggc_pkg::COLOR_W;

  pggc_pkg::state_t state, state_next;

  logic [pggc_pkg::COUNT_W-1:0] node_count;
  logic [pggc_pkg::LIMIT_W-1:0] color_limit;

  logic [IW-1:0]   ea, eb, i, j, nm1, cnt, rank_i;
  logic [IW:0]     deg_acc, deg_i;
  logic [NL-1:0]   adj_vld, row_i;
  logic [63:0]     used;
  logic [CW-1:0]   c, col_i;
  logic [pggc_pkg::PASS_W-1:0] pass;
  logic            cur, first, changed;

  logic            adj_we, deg_we, rank_we, col_we;
  logic [IW-1:0]   adj_waddr, adj_raddr, deg_waddr, deg_raddr, rank_waddr, rank_raddr;
  logic [IW:0]     col_waddr, col_raddr;
  logic [NL-1:0]   adj_wdata, adj_rdata;
  logic [IW:0]     deg_rdata;
  logic [IW-1:0]   rank_rdata;
  logic [CW-1:0]   col_rdata, col_j;

  logic [pggc_pkg::COUNT_W-1:0] n_min;
  logic            edge_ok, cfg_wr, last_i, last_j, thr_ok, stop, fail;
  logic [pggc_pkg::PASS_W-1:0] pass_inc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == pggc_pkg::REG_COLOR_LIMIT) ?
                  {21'd0, color_limit} : {25'd0, node_count};

  assign busy    = (state != pggc_pkg::ST_IDLE);
  assign n_min   = (node_count > 7'(NL)) ? 7'(NL) : node_count;
  assign edge_ok = (node_a != node_b) && (7'(node_a) < 7'(NL)) && (7'(node_b) < 7'(NL));
  assign last_i  = (i == nm1);
  assign last_j  = (j == nm1);
  assign col_j   = first ? '0 : col_rdata;
  assign thr_ok  = (pass >= 12'd6) || (7'(rank_rdata) <= (7'd1 << pass[2:0]));
  assign pass_inc = pass + 12'd1;
  assign fail    = pass_inc > {1'b0, color_limit};
  assign stop    = !changed || fail;

  pggc_ram #(.WIDTH(NL), .DEPTH(NL)) u_adj (
    .clk, .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  pggc_ram #(.WIDTH(IW + 1), .DEPTH(NL)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_acc),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );

  pggc_ram #(.WIDTH(IW), .DEPTH(NL)) u_rank (
    .clk, .we(rank_we), .waddr(rank_waddr), .wdata(cnt),
    .raddr(rank_raddr), .rdata(rank_rdata)
  );

  pggc_ram #(.WIDTH(CW), .DEPTH(2 << IW)) u_col (
    .clk, .we(col_we), .waddr(col_waddr), .wdata(c),
    .raddr(col_raddr), .rdata(col_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pggc_pkg::ST_IDLE: begin
        if (start) begin
          if (cmd == pggc_pkg::CMD_EDGE && edge_ok) begin
            state_next = pggc_pkg::ST_E_RDA;
          end else if (cmd == pggc_pkg::CMD_RUN && n_min != '0) begin
            state_next = pggc_pkg::ST_DEG_RD;
          end
        end
      end
      pggc_pkg::ST_E_RDA:   state_next = pggc_pkg::ST_E_WRA;
      pggc_pkg::ST_E_WRA:   state_next = pggc_pkg::ST_E_WRB;
      pggc_pkg::ST_E_WRB:   state_next = pggc_pkg::ST_IDLE;
      pggc_pkg::ST_DEG_RD:  state_next = pggc_pkg::ST_DEG_LD;
      pggc_pkg::ST_DEG_LD:  state_next = pggc_pkg::ST_DEG_CNT;
      pggc_pkg::ST_DEG_CNT: state_next = last_j ? pggc_pkg::ST_DEG_WR : pggc_pkg::ST_DEG_CNT;
      pggc_pkg::ST_DEG_WR:  state_next = last_i ? pggc_pkg::ST_RK_RDI : pggc_pkg::ST_DEG_RD;
      pggc_pkg::ST_RK_RDI:  state_next = pggc_pkg::ST_RK_LDI;
      pggc_pkg::ST_RK_LDI:  state_next = pggc_pkg::ST_RK_RDJ;
      pggc_pkg::ST_RK_RDJ:  state_next = pggc_pkg::ST_RK_CMP;
      pggc_pkg::ST_RK_CMP:  state_next = last_j ? pggc_pkg::ST_RK_WR : pggc_pkg::ST_RK_RDJ;
      pggc_pkg::ST_RK_WR:   state_next = last_i ? pggc_pkg::ST_CP_RDI : pggc_pkg::ST_RK_RDI;
      pggc_pkg::ST_CP_RDI:  state_next = pggc_pkg::ST_CP_LDI;
      pggc_pkg::ST_CP_LDI:  state_next = pggc_pkg::ST_CP_RDJ;
      pggc_pkg::ST_CP_RDJ:  state_next = pggc_pkg::ST_CP_CHK;
      pggc_pkg::ST_CP_CHK:  state_next = last_j ? pggc_pkg::ST_CP_SCAN : pggc_pkg::ST_CP_RDJ;
      pggc_pkg::ST_CP_SCAN: begin
        if (!used[c] || c == pggc_pkg::COLOR_MAX) begin
          state_next = pggc_pkg::ST_CP_WR;
        end
      end
      pggc_pkg::ST_CP_WR:   state_next = last_i ? pggc_pkg::ST_CP_END : pggc_pkg::ST_CP_RDI;
      pggc_pkg::ST_CP_END:  state_next = stop ? pggc_pkg::ST_OUT_RD : pggc_pkg::ST_CP_RDI;
      pggc_pkg::ST_OUT_RD:  state_next = pggc_pkg::ST_OUT_WR;
      pggc_pkg::ST_OUT_WR:  state_next = last_i ? pggc_pkg::ST_IDLE : pggc_pkg::ST_OUT_RD;
      default:              state_next = pggc_pkg::ST_IDLE;
    endcase
  end

  // ram controls
  always_comb begin
    adj_we     = 1'b0;
    adj_waddr  = ea;
    adj_wdata  = (adj_vld[ea] ? adj_rdata : '0) | ({{(NL-1){1'b0}}, 1'b1} << eb);
    adj_raddr  = i;
    deg_we     = 1'b0;
    deg_waddr  = i;
    deg_raddr  = i;
    rank_we    = 1'b0;
    rank_waddr = i;
    rank_raddr = i;
    col_we     = 1'b0;
    col_waddr  = {~cur, i};
    col_raddr  = {cur, i};
    case (state)
      pggc_pkg::ST_E_RDA: adj_raddr = ea;
      pggc_pkg::ST_E_WRA: begin
        adj_we    = 1'b1;
        adj_raddr = eb;
      end
      pggc_pkg::ST_E_WRB: begin
        adj_we    = 1'b1;
        adj_waddr = eb;
        adj_wdata = (adj_vld[eb] ? adj_rdata : '0) | ({{(NL-1){1'b0}}, 1'b1} << ea);
      end
      pggc_pkg::ST_DEG_WR: deg_we = 1'b1;
      pggc_pkg::ST_RK_RDJ: deg_raddr = j;
      pggc_pkg::ST_RK_WR:  rank_we = 1'b1;
      pggc_pkg::ST_CP_RDJ: begin
        rank_raddr = j;
        col_raddr  = {cur, j};
      end
      pggc_pkg::ST_CP_WR: col_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pggc_pkg::ST_IDLE;
      node_count  <= 7'd64;
      color_limit <= 11'd32;
      adj_vld     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= 1'b0;
      if (cfg_wr) begin
        if (paddr[2] == pggc_pkg::REG_NODE_COUNT) begin
          node_count <= pwdata[6:0];
        end else begin
          color_limit <= pwdata[10:0];
        end
      end
      if (state == pggc_pkg::ST_IDLE && start && cmd == pggc_pkg::CMD_CLEAR) begin
        adj_vld <= '0;
      end
      if (state == pggc_pkg::ST_E_WRA) begin
        adj_vld[ea] <= 1'b1;
      end
      if (state == pggc_pkg::ST_E_WRB) begin
        adj_vld[eb] <= 1'b1;
      end
      if (state == pggc_pkg::ST_OUT_WR) begin
        out_valid <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      pggc_pkg::ST_IDLE: begin
        ea  <= node_a[IW-1:0];
        eb  <= node_b[IW-1:0];
        nm1 <= IW'(n_min - 7'd1);
        i   <= '0;
      end
      pggc_pkg::ST_DEG_LD: begin
        row_i   <= adj_vld[i] ? adj_rdata : '0;
        j       <= '0;
        deg_acc <= '0;
      end
      pggc_pkg::ST_DEG_CNT: begin
        deg_acc <= deg_acc + (IW + 1)'(row_i[j]);
        j       <= j + 1'b1;
      end
      pggc_pkg::ST_DEG_WR: i <= last_i ? '0 : i + 1'b1;
      pggc_pkg::ST_RK_LDI: begin
        deg_i <= deg_rdata;
        j     <= '0;
        cnt   <= '0;
      end
      pggc_pkg::ST_RK_CMP: begin
        if (deg_rdata > deg_i || (deg_rdata == deg_i && j > i)) begin
          cnt <= cnt + 1'b1;
        end
        j <= j + 1'b1;
      end
      pggc_pkg::ST_RK_WR: begin
        i <= last_i ? '0 : i + 1'b1;
        if (last_i) begin
          pass    <= '0;
          cur     <= 1'b0;
          first   <= 1'b1;
          changed <= 1'b0;
        end
      end
      pggc_pkg::ST_CP_LDI: begin
        row_i  <= adj_vld[i] ? adj_rdata : '0;
        rank_i <= rank_rdata;
        col_i  <= first ? '0 : col_rdata;
        j      <= '0;
        used   <= '0;
        c      <= '0;
      end
      pggc_pkg::ST_CP_CHK: begin
        if (row_i[j] && rank_rdata < rank_i && thr_ok) begin
          used[col_j] <= 1'b1;
        end
        j <= j + 1'b1;
      end
      pggc_pkg::ST_CP_SCAN: begin
        if (used[c] && c != pggc_pkg::COLOR_MAX) begin
          c <= c + 1'b1;
        end
      end
      pggc_pkg::ST_CP_WR: begin
        if (c != col_i) begin
          changed <= 1'b1;
        end
        i <= last_i ? '0 : i + 1'b1;
      end
      pggc_pkg::ST_CP_END: begin
        pass    <= pass_inc;
        cur     <= ~cur;
        first   <= 1'b0;
        changed <= 1'b0;
        failed  <= fail;
      end
      pggc_pkg::ST_OUT_WR: begin
        node       <= 6'(i);
        node_color <= col_rdata;
        rank       <= 6'(rank_rdata);
        passes     <= pass[10:0];
        last       <= last_i;
        i          <= i + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/pggc_checker.sv
// ----------------------------------------------------------------------------
// pggc_checker
// port level checks of the greedy graph coloring block
// ----------------------------------------------------------------------------
`default_nettype none

module pggc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        last,
  input wire logic        failed,
  input wire logic [10:0] passes,
  input wire logic        pready
);

  // results other than the last one come while the request is still open
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> busy)
    else $error("result before last seen while idle");

  // no two results come back to back
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |=> !out_valid)
    else $error("results back to back");

  // a result always follows a busy cycle
  a_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result without a run");

  // at least one pass is reported unless the run failed
  a_passes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (passes != 11'd0) || failed)
    else $error("zero passes reported");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind parallel_greedy_graph_coloring pggc_checker u_pggc_checker (.*);

`default_nettype wire
